### design/quoted_printable_encoder_assert.svh
// Assertion macros for the quoted-printable encoder checker.
// Used by qpe_checker.sv only; needs nothing else.
`ifndef QUOTED_PRINTABLE_ENCODER_ASSERT_SVH
`define QUOTED_PRINTABLE_ENCODER_ASSERT_SVH

// Property checked at every edge outside reset
`define QPE_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Property checked at every edge, reset included
`define QPE_ASSERT_ALL(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### design/qpe_pkg.sv
// Shared types, character codes and helpers for the quoted-printable encoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package qpe_pkg;

    // Character codes
    localparam logic [7:0] CHR_TAB = 8'd9;
    localparam logic [7:0] CHR_LF  = 8'd10;
    localparam logic [7:0] CHR_CR  = 8'd13;
    localparam logic [7:0] CHR_SP  = 8'd32;
    localparam logic [7:0] CHR_EQ  = 8'd61;

    // Configuration
    localparam logic [7:0] LINE_LIMIT_RESET = 8'd76;
    localparam logic       REG_LINE_LIMIT   = 1'b0;

    // How the back end writes out one unit
    typedef enum logic [1:0] {
        KIND_LIT = 2'd0,   // one character, room check first
        KIND_ENC = 2'd1,   // '=' and two hex digits, room check first
        KIND_LF  = 2'd2    // LF closing a CR, no room check
    } t_kind;

    // One unit queued between front and back
    typedef struct packed {
        logic [7:0] data;
        t_kind      kind;
        logic       last;
    } t_unit;

    // Uppercase hex digit of a nibble
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] w;
        w = {4'b0000, v};
        return (v < 4'd10) ? (8'd48 + w) : (8'd55 + w);
    endfunction

    // Bytes that may pass as they are
    function automatic logic is_plain(input logic [7:0] b);
        return ((b >= 8'd33) && (b <= 8'd60)) || ((b >= 8'd62) && (b <= 8'd126)) ||
               (b == CHR_TAB) || (b == CHR_SP) || (b == CHR_CR) || (b == CHR_LF);
    endfunction

endpackage

`default_nettype wire

### design/quoted_printable_encoder.sv
// Quoted-printable encoder: raw bytes in, encoded characters out, one character
// a cycle while the receiver is ready. The front end accepts one byte a cycle
// while its queue has room and no second unit is pending; a byte that releases
// a held space or tab as well as its own characters holds the input until its
// second unit is queued. The output side runs at one character per cycle when
// not stalled, so a hex-encoded byte gives three characters and a soft break
// adds three more; the sustained rate is set by the back end's single character
// port. A byte's first character passes through the queue and output register.
// Top level; depends on qpe_pkg, qpe_front, qpe_fifo and qpe_back.
`timescale 1ns / 1ps
`default_nettype none

module quoted_printable_encoder
    import qpe_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // byte stream in
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    input  wire logic [7:0]  i_s_tdata,   // [7:0] data_byte
    input  wire logic        i_s_tlast,
    // character stream out
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    output logic [7:0]       o_m_tdata,   // [7:0] out_char
    output logic             o_m_tlast,
    // register port
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    logic [7:0] r_line_limit;
    logic       q_wr, q_rd, q_valid, q_full;
    t_unit      q_wdata, q_rdata;

    // Register port
    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINE_LIMIT) ? {24'd0, r_line_limit} : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_limit <= LINE_LIMIT_RESET;
        end else if (psel && penable && pwrite && pready && (paddr[2] == REG_LINE_LIMIT)) begin
            r_line_limit <= pwdata[7:0];
        end
    end

    qpe_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_s_tvalid),
        .o_ready  (o_s_tready),
        .i_data   (i_s_tdata),
        .i_last   (i_s_tlast),
        .i_q_full (q_full),
        .o_push   (q_wr),
        .o_unit   (q_wdata)
    );

    qpe_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (q_wr),
        .i_wdata (q_wdata),
        .i_rd    (q_rd),
        .o_rdata (q_rdata),
        .o_valid (q_valid),
        .o_full  (q_full)
    );

    qpe_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_line_limit (r_line_limit),
        .i_q_valid    (q_valid),
        .i_unit       (q_rdata),
        .o_pop        (q_rd),
        .o_valid      (o_m_tvalid),
        .i_ready      (i_m_tready),
        .o_char       (o_m_tdata),
        .o_last       (o_m_tlast)
    );

endmodule

`default_nettype wire

### design/qpe_fifo.sv
// Short queue of encoding units between the front and back ends.
// Depends on qpe_pkg for the unit type.
`timescale 1ns / 1ps
`default_nettype none

module qpe_fifo
    import qpe_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_wr,
    input  wire t_unit i_wdata,
    input  wire logic  i_rd,
    output t_unit      o_rdata,
    output logic       o_valid,
    output logic       o_full
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [PW-1:0] PTR_LAST = PW'(DEPTH - 1);
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);

    t_unit         r_mem [DEPTH];
    logic [PW-1:0] r_wptr, r_rptr;
    logic [CW-1:0] r_cnt;

    assign o_rdata = r_mem[r_rptr];
    assign o_valid = (r_cnt != '0);
    assign o_full  = (r_cnt == CNT_FULL);

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_wdata;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr <= '0;
            r_rptr <= '0;
            r_cnt  <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == PTR_LAST) ? '0 : r_wptr + 1'b1;
            end
            if (i_rd) begin
                r_rptr <= (r_rptr == PTR_LAST) ? '0 : r_rptr + 1'b1;
            end
            if (i_wr && !i_rd) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_wr && i_rd) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### design/qpe_front.sv
// Front end: takes raw bytes, resolves the held space or tab, and queues units.
// Depends on qpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpe_front
    import qpe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_valid,
    output logic            o_ready,
    input  wire logic [7:0] i_data,
    input  wire logic       i_last,
    input  wire logic       i_q_full,
    output logic            o_push,
    output t_unit           o_unit
);

    logic [7:0] r_held;
    logic       r_held_v;
    logic       r_after_cr;
    t_unit      r_pend;
    logic       r_pend_v;

    logic  acc, crlf, sp_tab, lf_close;
    t_unit unit_a, unit_b;
    logic  b_v;

    assign o_ready = !r_pend_v && !i_q_full;
    assign acc     = i_valid && o_ready;

    // Classify the incoming byte
    always_comb begin
        crlf     = (i_data == CHR_CR) || (i_data == CHR_LF);
        sp_tab   = (i_data == CHR_SP) || (i_data == CHR_TAB);
        lf_close = r_after_cr && (i_data == CHR_LF);

        // held space or tab goes out first, hex only before a line end
        unit_a.data = r_held;
        unit_a.kind = crlf ? KIND_ENC : KIND_LIT;
        unit_a.last = 1'b0;

        unit_b.data = i_data;
        unit_b.last = i_last;
        b_v         = 1'b1;
        if (lf_close) begin
            unit_b.kind = KIND_LF;
        end else if (!is_plain(i_data)) begin
            unit_b.kind = KIND_ENC;
        end else if (sp_tab) begin
            unit_b.kind = KIND_ENC;
            b_v         = i_last;
        end else begin
            unit_b.kind = KIND_LIT;
        end
    end

    // Queue write: pending second unit, else the first unit of this byte
    always_comb begin
        if (r_pend_v) begin
            o_push = !i_q_full;
            o_unit = r_pend;
        end else begin
            o_push = acc && (r_held_v || b_v);
            o_unit = r_held_v ? unit_a : unit_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_held <= i_data;
            r_pend <= unit_b;
        end
    end

    // Lookahead and line-end state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_held_v   <= 1'b0;
            r_after_cr <= 1'b0;
            r_pend_v   <= 1'b0;
        end else if (acc) begin
            r_held_v   <= !i_last && sp_tab;
            r_after_cr <= !i_last && !lf_close && (i_data == CHR_CR);
            r_pend_v   <= r_held_v && b_v;
        end else if (r_pend_v && !i_q_full) begin
            r_pend_v <= 1'b0;
        end
    end

endmodule

`default_nettype wire

### design/qpe_back.sv
// Back end: writes each unit out one character a cycle while not stalled,
// with soft breaks. Depends on qpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module qpe_back
    import qpe_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic [7:0] i_line_limit,
    input  wire logic       i_q_valid,
    input  wire t_unit      i_unit,
    output logic            o_pop,
    output logic            o_valid,
    input  wire logic       i_ready,
    output logic [7:0]      o_char,
    output logic            o_last
);

    logic [2:0] r_step;
    logic       r_brk;
    logic [7:0] r_count;
    logic       r_ovalid;
    logic [7:0] r_char;
    logic       r_olast;

    logic        fire, brk_now, brk, is_end;
    logic [1:0]  len;
    logic [9:0]  cnt_ext, lim_ext;
    logic [2:0]  off, total, j;
    logic [7:0]  chr, n_count;

    assign o_valid = r_ovalid;
    assign o_char  = r_char;
    assign o_last  = r_olast;
    assign fire    = i_q_valid && (!r_ovalid || i_ready);
    assign o_pop   = fire && is_end;

    // Room check and character selection
    always_comb begin
        len     = (i_unit.kind == KIND_ENC) ? 2'd3 : 2'd1;
        cnt_ext = {2'b00, r_count} + {8'd0, len};
        lim_ext = {2'b00, i_line_limit} - 10'd2;
        brk_now = (i_unit.kind != KIND_LF) && ($signed(cnt_ext) > $signed(lim_ext));
        brk     = (r_step == 3'd0) ? brk_now : r_brk;
        off     = brk ? 3'd3 : 3'd0;
        total   = off + {1'b0, len};
        j       = r_step - off;
        is_end  = (r_step == total - 3'd1);

        if (brk && (r_step < 3'd3)) begin
            case (r_step)
                3'd0:    chr = CHR_EQ;
                3'd1:    chr = CHR_CR;
                default: chr = CHR_LF;
            endcase
        end else if (i_unit.kind == KIND_ENC) begin
            case (j)
                3'd0:    chr = CHR_EQ;
                3'd1:    chr = hex_digit(i_unit.data[7:4]);
                default: chr = hex_digit(i_unit.data[3:0]);
            endcase
        end else begin
            chr = i_unit.data;
        end

        // count after this unit, committed on its first character
        if (i_unit.last || (i_unit.kind == KIND_LF) ||
            ((i_unit.kind == KIND_LIT) && (i_unit.data == CHR_LF))) begin
            n_count = 8'd0;
        end else begin
            n_count = (brk_now ? 8'd0 : r_count) + {6'd0, len};
        end
    end

    // Output word register
    always_ff @(posedge i_clk) begin
        if (fire) begin
            r_char  <= chr;
            r_olast <= i_unit.last && is_end;
        end
    end

    // Sequencer and line count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step   <= 3'd0;
            r_brk    <= 1'b0;
            r_count  <= 8'd0;
            r_ovalid <= 1'b0;
        end else begin
            if (fire) begin
                r_ovalid <= 1'b1;
                r_step   <= is_end ? 3'd0 : r_step + 3'd1;
                if (r_step == 3'd0) begin
                    r_brk   <= brk_now;
                    r_count <= n_count;
                end
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

endmodule

`default_nettype wire

### design/qpe_checker.sv
// Port-level checks for the quoted-printable encoder, bound to the top level.
// Depends on quoted_printable_encoder_assert.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "quoted_printable_encoder_assert.svh"

module qpe_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_m_tvalid,
    input wire logic        i_m_tready,
    input wire logic [7:0]  o_m_tdata,
    input wire logic        o_m_tlast,
    input wire logic        psel,
    input wire logic        penable,
    input wire logic        pwrite,
    input wire logic [2:0]  paddr,
    input wire logic [31:0] pwdata,
    input wire logic [31:0] prdata,
    input wire logic        pready
);

    // A stalled word holds
    `QPE_ASSERT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast), "output word changed while stalled")

    // Nothing comes out straight after reset
    `QPE_ASSERT_ALL(a_rst_idle, i_clk, i_rst_n && !$past(i_rst_n) |-> !o_m_tvalid, "output valid after reset")

    // A message never ends on '=': breaks precede units, '=' is always hex-encoded
    `QPE_ASSERT(a_last_not_eq, i_clk, i_rst_n, o_m_tvalid && o_m_tlast |-> o_m_tdata != 8'd61, "message ends on an equals sign")

    // A line limit write reads back
    `QPE_ASSERT(a_cfg_rdback, i_clk, i_rst_n, psel && penable && pwrite && pready && !paddr[2] ##1 !paddr[2] |-> prdata == {24'd0, $past(pwdata[7:0])}, "line limit read back wrong")

endmodule

bind quoted_printable_encoder qpe_checker u_qpe_checker (.*);

`default_nettype wire
